### rtl/back_forward_call_history_defines.svh
// Assertion macros shared by the call history RTL.
`ifndef BACK_FORWARD_CALL_HISTORY_DEFINES_SVH
`define BACK_FORWARD_CALL_HISTORY_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define BFCH_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bfch check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define BFCH_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bfch check failed");

`else

`define BFCH_ASSERT_NOW(label, ante, cons)
`define BFCH_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/bfch_pkg.sv
// Shared types and constants of the call history block.
package bfch_pkg;

	localparam int STACK_DEPTH_DEF = 32;
	localparam int LOG_DEPTH_DEF   = 32;

	localparam int NUM_W  = 64;
	localparam int TIME_W = 32;
	localparam int REC_W  = NUM_W + TIME_W;

	typedef enum logic [1:0] {
		MODE_CALL    = 2'd0,
		MODE_BACK    = 2'd1,
		MODE_REDIAL  = 2'd2,
		MODE_HISTORY = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK          = 2'd0,
		STAT_NO_EARLIER  = 2'd1,
		STAT_NO_REDIAL   = 2'd2,
		STAT_LOG_EMPTY   = 2'd3
	} status_t;

endpackage

### rtl/back_forward_call_history.sv
// Back/forward call history: two record stacks and a call log in block RAM.
//
//  channel   dir  tdata (low bit up)                  tuser       tlast
//  s_axis    in   phone_number[63:0], call_time[95:64] mode[1:0]   -
//  m_axis    out  number_out[63:0], time_out[95:64]    status[1:0] last
//
// Call and any refused request: result loaded at the accept edge.
// Back: top read, then new-top read while the top goes to the
// forward stack. Redial: forward-top read, then back push.
// History: first log read at accept, then one record per cycle, paced by the log
// RAM read port; a stalled m_axis holds the pipeline without losing data.
// Reset clears state, output valid, counts and pointers only; no RAM clearing pass is needed.
`include "back_forward_call_history_defines.svh"

module back_forward_call_history #(
	parameter int STACK_DEPTH = bfch_pkg::STACK_DEPTH_DEF,
	parameter int LOG_DEPTH   = bfch_pkg::LOG_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [bfch_pkg::REC_W-1:0] s_axis_tdata,  // phone_number, call_time
	input  logic [1:0]                 s_axis_tuser,  // mode
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [bfch_pkg::REC_W-1:0] m_axis_tdata,  // number_out, time_out
	output logic [1:0]                 m_axis_tuser,  // status
	output logic                       m_axis_tlast   // last
);

	// stack slots, stack counts (hold 0..STACK_DEPTH)
	localparam int SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SCW = $clog2(STACK_DEPTH + 1);
	// both stacks share one RAM: top address bit picks back (0) or forward (1)
	localparam int ST_DEPTH = 2 * (1 << SAW);
	// log slots and counts
	localparam int LAW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
	localparam int LCW = $clog2(LOG_DEPTH + 1);

	localparam int REC_W = bfch_pkg::REC_W;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_BK_RD  = 5'b00010,
		ST_BK_OUT = 5'b00100,
		ST_RD_OUT = 5'b01000,
		ST_HIST   = 5'b10000
	} state_t;

	// circular wrap of a sum known to stay below twice the depth
	function automatic logic [SAW-1:0] s_wrap(input logic [SAW:0] sum);
		logic [SAW:0] adj;
		adj = (sum >= (SAW+1)'(STACK_DEPTH)) ? sum - (SAW+1)'(STACK_DEPTH) : sum;
		return adj[SAW-1:0];
	endfunction

	function automatic logic [LAW-1:0] l_wrap(input logic [LAW:0] sum);
		logic [LAW:0] adj;
		adj = (sum >= (LAW+1)'(LOG_DEPTH)) ? sum - (LAW+1)'(LOG_DEPTH) : sum;
		return adj[LAW-1:0];
	endfunction

	state_t state_q, state_d;

	// each stack is a ring: base is the oldest slot, a push on a full stack
	// overwrites base and moves it on
	logic [SAW-1:0] back_base_q, back_base_d;
	logic [SCW-1:0] back_cnt_q, back_cnt_d;
	logic [SAW-1:0] fwd_base_q, fwd_base_d;
	logic [SCW-1:0] fwd_cnt_q, fwd_cnt_d;
	logic [LAW-1:0] log_head_q, log_head_d;
	logic [LCW-1:0] log_cnt_q, log_cnt_d;
	logic [LCW-1:0] hist_idx_q, hist_idx_d;

	logic                 ovalid_q;
	logic [REC_W-1:0]     odata_q;
	bfch_pkg::status_t    ostat_q;
	logic                 olast_q;

	logic                 o_load;
	logic [REC_W-1:0]     o_data;
	bfch_pkg::status_t    o_stat;
	logic                 o_last;

	logic                    st_we, st_re;
	logic [SAW:0]            st_waddr, st_raddr;
	logic [REC_W-1:0]        st_wdata, st_rdata;
	logic                    lg_we, lg_re;
	logic [LAW-1:0]          lg_waddr, lg_raddr;
	logic [REC_W-1:0]        lg_rdata;

	logic              in_acc, out_free;
	bfch_pkg::mode_t   in_mode;
	logic [SAW-1:0]    back_push_slot, back_top_slot, fwd_push_slot, fwd_top_slot;
	logic              back_full, fwd_full, log_full, hist_last;
	logic [LAW-1:0]    log_tail, hist_next_slot;

	assign out_free      = !ovalid_q || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && out_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign in_mode       = bfch_pkg::mode_t'(s_axis_tuser);

	assign back_push_slot = s_wrap({1'b0, back_base_q} + (SAW+1)'(back_cnt_q));
	assign back_top_slot  = s_wrap({1'b0, back_base_q} + (SAW+1)'(back_cnt_q) - 1'b1);
	assign fwd_push_slot  = s_wrap({1'b0, fwd_base_q} + (SAW+1)'(fwd_cnt_q));
	assign fwd_top_slot   = s_wrap({1'b0, fwd_base_q} + (SAW+1)'(fwd_cnt_q) - 1'b1);
	assign back_full      = (back_cnt_q == SCW'(STACK_DEPTH));
	assign fwd_full       = (fwd_cnt_q == SCW'(STACK_DEPTH));

	assign log_tail       = l_wrap({1'b0, log_head_q} + (LAW+1)'(log_cnt_q));
	assign log_full       = (log_cnt_q == LCW'(LOG_DEPTH));
	assign hist_next_slot = l_wrap({1'b0, log_head_q} + (LAW+1)'(hist_idx_q) + 1'b1);
	assign hist_last      = (hist_idx_q == LCW'(log_cnt_q - 1'b1));

	always_comb begin
		state_d     = state_q;
		back_base_d = back_base_q;
		back_cnt_d  = back_cnt_q;
		fwd_base_d  = fwd_base_q;
		fwd_cnt_d   = fwd_cnt_q;
		log_head_d  = log_head_q;
		log_cnt_d   = log_cnt_q;
		hist_idx_d  = hist_idx_q;
		st_we       = 1'b0;
		st_waddr    = {1'b0, back_push_slot};
		st_wdata    = s_axis_tdata;
		st_re       = 1'b0;
		st_raddr    = {1'b0, back_top_slot};
		lg_we       = 1'b0;
		lg_waddr    = log_tail;
		lg_re       = 1'b0;
		lg_raddr    = log_head_q;
		o_load      = 1'b0;
		o_data      = '0;
		o_stat      = bfch_pkg::STAT_OK;
		o_last      = 1'b1;

		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (in_mode)
						bfch_pkg::MODE_CALL: begin
							st_we = 1'b1;
							if (back_full) begin
								back_base_d = s_wrap({1'b0, back_base_q} + 1'b1);
							end else begin
								back_cnt_d = back_cnt_q + 1'b1;
							end
							lg_we = 1'b1;
							if (log_full) begin
								log_head_d = l_wrap({1'b0, log_head_q} + 1'b1);
							end else begin
								log_cnt_d = log_cnt_q + 1'b1;
							end
							fwd_cnt_d = '0;
							o_load    = 1'b1;
							o_data    = s_axis_tdata;
						end
						bfch_pkg::MODE_BACK: begin
							if (back_cnt_q < SCW'(2)) begin
								o_load = 1'b1;
								o_stat = bfch_pkg::STAT_NO_EARLIER;
							end else begin
								st_re      = 1'b1;
								back_cnt_d = back_cnt_q - 1'b1;
								state_d    = ST_BK_RD;
							end
						end
						bfch_pkg::MODE_REDIAL: begin
							if (fwd_cnt_q == '0) begin
								o_load = 1'b1;
								o_stat = bfch_pkg::STAT_NO_REDIAL;
							end else begin
								st_re     = 1'b1;
								st_raddr  = {1'b1, fwd_top_slot};
								fwd_cnt_d = fwd_cnt_q - 1'b1;
								state_d   = ST_RD_OUT;
							end
						end
						bfch_pkg::MODE_HISTORY: begin
							if (log_cnt_q == '0) begin
								o_load = 1'b1;
								o_stat = bfch_pkg::STAT_LOG_EMPTY;
							end else begin
								lg_re      = 1'b1;
								hist_idx_d = '0;
								state_d    = ST_HIST;
							end
						end
						default: begin
							o_load = 1'b0;
						end
					endcase
				end
			end
			ST_BK_RD: begin
				// old top goes to the forward stack, new back top is read
				st_we    = 1'b1;
				st_waddr = {1'b1, fwd_push_slot};
				st_wdata = st_rdata;
				if (fwd_full) begin
					fwd_base_d = s_wrap({1'b0, fwd_base_q} + 1'b1);
				end else begin
					fwd_cnt_d = fwd_cnt_q + 1'b1;
				end
				st_re   = 1'b1;
				state_d = ST_BK_OUT;
			end
			ST_BK_OUT: begin
				if (out_free) begin
					o_load  = 1'b1;
					o_data  = st_rdata;
					state_d = ST_IDLE;
				end
			end
			ST_RD_OUT: begin
				if (out_free) begin
					o_load   = 1'b1;
					o_data   = st_rdata;
					st_we    = 1'b1;
					st_wdata = st_rdata;
					if (back_full) begin
						back_base_d = s_wrap({1'b0, back_base_q} + 1'b1);
					end else begin
						back_cnt_d = back_cnt_q + 1'b1;
					end
					state_d = ST_IDLE;
				end
			end
			ST_HIST: begin
				if (out_free) begin
					o_load = 1'b1;
					o_data = lg_rdata;
					o_last = hist_last;
					if (hist_last) begin
						state_d = ST_IDLE;
					end else begin
						hist_idx_d = hist_idx_q + 1'b1;
						lg_re      = 1'b1;
						lg_raddr   = hist_next_slot;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			back_base_q <= '0;
			back_cnt_q  <= '0;
			fwd_base_q  <= '0;
			fwd_cnt_q   <= '0;
			log_head_q  <= '0;
			log_cnt_q   <= '0;
			hist_idx_q  <= '0;
			ovalid_q    <= 1'b0;
		end else begin
			state_q     <= state_d;
			back_base_q <= back_base_d;
			back_cnt_q  <= back_cnt_d;
			fwd_base_q  <= fwd_base_d;
			fwd_cnt_q   <= fwd_cnt_d;
			log_head_q  <= log_head_d;
			log_cnt_q   <= log_cnt_d;
			hist_idx_q  <= hist_idx_d;
			if (o_load) begin
				ovalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// output payload, no reset needed
	always_ff @(posedge clk) begin
		if (o_load) begin
			odata_q <= o_data;
			ostat_q <= o_stat;
			olast_q <= o_last;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = odata_q;
	assign m_axis_tuser  = ostat_q;
	assign m_axis_tlast  = olast_q;

	bfch_ram #(
		.WIDTH (REC_W),
		.DEPTH (ST_DEPTH)
	) u_stack_ram (
		.clk     (clk),
		.wr_en   (st_we),
		.wr_addr (st_waddr),
		.wr_data (st_wdata),
		.rd_en   (st_re),
		.rd_addr (st_raddr),
		.rd_data (st_rdata)
	);

	bfch_ram #(
		.WIDTH (REC_W),
		.DEPTH (LOG_DEPTH)
	) u_log_ram (
		.clk     (clk),
		.wr_en   (lg_we),
		.wr_addr (lg_waddr),
		.wr_data (s_axis_tdata),
		.rd_en   (lg_re),
		.rd_addr (lg_raddr),
		.rd_data (lg_rdata)
	);

	// a call always clears the forward stack
	`BFCH_ASSERT_NEXT(a_call_clears_fwd, in_acc && (in_mode == bfch_pkg::MODE_CALL), fwd_cnt_q == '0)
	// a successful back removes exactly one back record
	`BFCH_ASSERT_NEXT(a_back_pops_one, in_acc && (in_mode == bfch_pkg::MODE_BACK) && (back_cnt_q >= SCW'(2)), back_cnt_q == $past(back_cnt_q) - 1'b1)
	// a status result is final and carries no record
	`BFCH_ASSERT_NOW(a_status_result, m_axis_tvalid && (m_axis_tuser != bfch_pkg::STAT_OK), m_axis_tlast && (m_axis_tdata == '0))
	// counts never pass their store depths
	`BFCH_ASSERT_NOW(a_count_bounds, 1'b1, (back_cnt_q <= SCW'(STACK_DEPTH)) && (fwd_cnt_q <= SCW'(STACK_DEPTH)) && (log_cnt_q <= LCW'(LOG_DEPTH)))

endmodule

### rtl/bfch_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module bfch_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds while rd_en is low
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
